>>> rtl/cht_pkg.sv
// shared types and constants for the chained hash table
// no dependencies
`default_nettype none
package cht_pkg;
	localparam int BUCKETS = 256;
	localparam int POOL = 256;
	localparam int BW = $clog2(BUCKETS);
	localparam int NW = $clog2(POOL);
	localparam int KEY_W = 16;
	localparam int DATA_W = 32;
	localparam logic [7:0] BUCKET_COUNT_RST = 8'd100;

	typedef enum logic [1:0] {
		FN_INSERT = 2'd0,
		FN_SEARCH = 2'd1,
		FN_DELETE = 2'd2,
		FN_NONE = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_HASH,
		S_HEAD,
		S_NODE_RD,
		S_NODE_CHK,
		S_FREE_RD,
		S_FREE_CHK,
		S_WRITE,
		S_OUT
	} state_t;

	// node word: key, payload, link valid, link
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [DATA_W-1:0] payload;
		logic lvalid;
		logic [NW-1:0] link;
	} node_t;

	localparam int NODE_W = $bits(node_t);
endpackage
`default_nettype wire

>>> rtl/cht_if.sv
// valid/ready channel interfaces for the chained hash table
// no dependencies
`default_nettype none
interface cht_req_if;
	logic valid;
	logic ready;
	logic [1:0] func;
	logic [15:0] key;
	logic [31:0] record_data;
	modport source (output valid, func, key, record_data, input ready);
	modport sink (input valid, func, key, record_data, output ready);
endinterface

interface cht_rsp_if;
	logic valid;
	logic ready;
	logic [1:0] status;
	logic [31:0] record_out;
	modport source (output valid, status, record_out, input ready);
	modport sink (input valid, status, record_out, output ready);
endinterface

interface cht_cfg_if;
	logic valid;
	logic ready;
	logic [7:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

>>> rtl/cht_ram.sv
// generic single write, single read ram with registered read
// no dependencies
`default_nettype none
module cht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

>>> rtl/chained_hash_table.sv
// top level of the chained hash table
// depends on cht_pkg, cht_if and cht_ram
`default_nettype none
// Hash table with separate chaining over a pool of cht_pkg::POOL nodes. Each request item
// is an insert, search or delete of a 16-bit key; the bucket is key mod bucket_count (0 means
// 256, clamped to BUCKETS). One request is handled at a time: the modulus is computed first
// (a restoring divider, two quotient bits a cycle), then the bucket head/tail ram is read, then
// the chain is walked through the node ram, each node taking a registered read and a compare.
// An empty bucket, a full pool or an unused code touches no node; linking behind an old tail
// adds a write, taking a node from the free list adds a read of the free head, and a delete
// ends with two writes (relink, then free-list push). Head valid bits are flip-flops cleared
// by reset, so no clearing pass is needed. The response sits in an output register; a new
// request is taken the cycle after it has been taken.
module chained_hash_table (
	input wire logic clk,
	input wire logic arst_n,
	cht_req_if.sink req,
	cht_rsp_if.source rsp,
	cht_cfg_if.sink cfg
);
	localparam int BW = cht_pkg::BW;
	localparam int NW = cht_pkg::NW;
	localparam int BUCKETS_T = cht_pkg::BUCKETS;

	cht_pkg::state_t state_q, state_d;
	logic [7:0] bcount_q;
	logic [1:0] func_q;
	logic [15:0] key_q;
	logic [31:0] data_q;
	logic [16:0] rem_q;
	logic [8:0] mod_q;
	logic [3:0] dcnt_q;
	logic [BW-1:0] bkt_q;
	logic [BUCKETS_T-1:0] hv_q;
	logic [NW-1:0] cur_q, prev_q, tail_q, newn_q;
	logic has_prev_q;
	logic [NW:0] steps_q;
	logic [NW-1:0] free_head_q;
	logic free_valid_q;
	logic [NW:0] fresh_q;
	logic [1:0] status_q;
	logic [31:0] rec_q;
	logic rsp_valid_q;

	// bucket ram: head and tail
	logic bk_we;
	logic [2*NW-1:0] bk_wdata, bk_rdata;
	logic [BW-1:0] bk_raddr;
	logic [NW-1:0] head_now, tail_now;
	// node ram, two write ports needed on delete: done in two write phases
	logic nd_we;
	logic [NW-1:0] nd_waddr, nd_raddr;
	cht_pkg::node_t nd_wdata, nd_rdata;
	cht_pkg::node_t cur_node_q;
	logic [1:0] wphase_q;
	// previous node word, kept for the delete relink
	cht_pkg::node_t prev_node_q;
	// old tail word, read right after the head lookup
	cht_pkg::node_t tail_node_q;
	logic tail_rd_q;

	// two restoring steps per cycle on the remainder
	logic [16:0] r1, r2;
	logic [16:0] t1, t2;

	cht_ram #(.WIDTH(2*NW), .DEPTH(cht_pkg::BUCKETS)) u_bucket (
		.clk, .we(bk_we), .waddr(bkt_q), .wdata(bk_wdata), .raddr(bk_raddr), .rdata(bk_rdata)
	);
	cht_ram #(.WIDTH(cht_pkg::NODE_W), .DEPTH(cht_pkg::POOL)) u_node (
		.clk, .we(nd_we), .waddr(nd_waddr), .wdata(nd_wdata), .raddr(nd_raddr),
		.rdata(nd_rdata)
	);
	assign head_now = bk_rdata[2*NW-1:NW];
	assign tail_now = bk_rdata[NW-1:0];
	// bucket address goes out with the last remainder step so the word is ready in S_HEAD
	assign bk_raddr = (state_q == cht_pkg::S_HASH) ? r2[BW-1:0] : bkt_q;

	assign req.ready = (state_q == cht_pkg::S_IDLE) && !rsp_valid_q;
	assign cfg.ready = 1'b1;
	assign rsp.valid = rsp_valid_q;
	assign rsp.status = status_q;
	assign rsp.record_out = rec_q;

	logic [8:0] mod_sel;
	always_comb begin
		mod_sel = (bcount_q == 8'd0) ? 9'd256 : {1'b0, bcount_q};
		if (mod_sel > 9'(cht_pkg::BUCKETS)) mod_sel = 9'(cht_pkg::BUCKETS);
	end

	always_comb begin
		t1 = {rem_q[15:0], key_q[15]};
		r1 = (t1 >= {8'd0, mod_q}) ? t1 - {8'd0, mod_q} : t1;
		t2 = {r1[15:0], key_q[14]};
		r2 = (t2 >= {8'd0, mod_q}) ? t2 - {8'd0, mod_q} : t2;
	end

	logic key_hit;
	assign key_hit = nd_rdata.key == key_q;
	logic head_valid_b;
	assign head_valid_b = hv_q[bkt_q];

	always_comb begin
		state_d = state_q;
		bk_we = 1'b0;
		bk_wdata = {head_now, tail_now};
		nd_we = 1'b0;
		nd_waddr = newn_q;
		nd_wdata = '0;
		nd_raddr = cur_q;
		case (state_q)
			cht_pkg::S_IDLE: if (req.valid && req.ready) state_d = cht_pkg::S_HASH;
			cht_pkg::S_HASH: if (dcnt_q == 4'd7) state_d = cht_pkg::S_HEAD;
			cht_pkg::S_HEAD: begin
				nd_raddr = tail_now;
				case (func_q)
					cht_pkg::FN_INSERT: begin
						if (free_valid_q) state_d = cht_pkg::S_FREE_RD;
						else if (fresh_q < (NW+1)'(cht_pkg::POOL)) state_d = cht_pkg::S_WRITE;
						else state_d = cht_pkg::S_OUT;
					end
					cht_pkg::FN_SEARCH, cht_pkg::FN_DELETE:
						state_d = head_valid_b ? cht_pkg::S_NODE_RD : cht_pkg::S_OUT;
					default: state_d = cht_pkg::S_OUT;
				endcase
			end
			cht_pkg::S_NODE_RD: state_d = cht_pkg::S_NODE_CHK;
			cht_pkg::S_NODE_CHK: begin
				if (key_hit) state_d = (func_q == cht_pkg::FN_DELETE) ? cht_pkg::S_WRITE
					: cht_pkg::S_OUT;
				else if (!nd_rdata.lvalid || steps_q == (NW+1)'(cht_pkg::POOL - 1))
					state_d = cht_pkg::S_OUT;
				else state_d = cht_pkg::S_NODE_RD;
			end
			cht_pkg::S_FREE_RD: begin
				nd_raddr = free_head_q;
				state_d = cht_pkg::S_FREE_CHK;
			end
			cht_pkg::S_FREE_CHK: state_d = cht_pkg::S_WRITE;
			cht_pkg::S_WRITE: begin
				if (func_q == cht_pkg::FN_INSERT) begin
					if (wphase_q == 2'd0) begin
						nd_we = 1'b1;
						nd_waddr = newn_q;
						nd_wdata = '{key: key_q, payload: data_q, lvalid: 1'b0, link: '0};
						bk_we = 1'b1;
						bk_wdata = {head_valid_b ? head_now : newn_q, newn_q};
						state_d = head_valid_b ? cht_pkg::S_WRITE : cht_pkg::S_OUT;
					end else begin
						// old tail links to the new node; payload kept via read-back
						nd_we = 1'b1;
						nd_waddr = tail_q;
						nd_wdata = tail_node_q;
						nd_wdata.lvalid = 1'b1;
						nd_wdata.link = newn_q;
						state_d = cht_pkg::S_OUT;
					end
				end else begin
					// delete: first relink, then push node on free list
					if (wphase_q == 2'd0) begin
						if (has_prev_q) begin
							nd_we = 1'b1;
							nd_waddr = prev_q;
							nd_wdata = prev_node_q;
							nd_wdata.lvalid = cur_node_q.lvalid;
							nd_wdata.link = cur_node_q.link;
							if (!cur_node_q.lvalid) begin
								bk_we = 1'b1;
								bk_wdata = {head_now, prev_q};
							end
						end else begin
							bk_we = 1'b1;
							bk_wdata = {cur_node_q.link, tail_now};
						end
						state_d = cht_pkg::S_WRITE;
					end else begin
						nd_we = 1'b1;
						nd_waddr = cur_q;
						nd_wdata = cur_node_q;
						nd_wdata.lvalid = free_valid_q;
						nd_wdata.link = free_head_q;
						state_d = cht_pkg::S_OUT;
					end
				end
			end
			cht_pkg::S_OUT: state_d = cht_pkg::S_IDLE;
			default: state_d = cht_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cht_pkg::S_IDLE;
			bcount_q <= cht_pkg::BUCKET_COUNT_RST;
			hv_q <= '0;
			free_valid_q <= 1'b0;
			fresh_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid && cfg.ready) bcount_q <= cfg.data;
			if (rsp_valid_q && rsp.ready) rsp_valid_q <= 1'b0;
			case (state_q)
				cht_pkg::S_HEAD: if (func_q == cht_pkg::FN_INSERT && !free_valid_q
						&& fresh_q < (NW+1)'(cht_pkg::POOL)) fresh_q <= fresh_q + 1'b1;
				cht_pkg::S_FREE_CHK: begin
					free_valid_q <= nd_rdata.lvalid;
				end
				cht_pkg::S_WRITE: begin
					if (func_q == cht_pkg::FN_INSERT && wphase_q == 2'd0)
						hv_q[bkt_q] <= 1'b1;
					if (func_q == cht_pkg::FN_DELETE && wphase_q == 2'd0 && !has_prev_q)
						hv_q[bkt_q] <= cur_node_q.lvalid;
					if (func_q == cht_pkg::FN_DELETE && wphase_q != 2'd0)
						free_valid_q <= 1'b1;
				end
				cht_pkg::S_OUT: rsp_valid_q <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			cht_pkg::S_IDLE: begin
				if (req.valid && req.ready) begin
					func_q <= req.func;
					key_q <= req.key;
					data_q <= req.record_data;
					rem_q <= '0;
					mod_q <= mod_sel;
					dcnt_q <= '0;
					wphase_q <= '0;
					has_prev_q <= 1'b0;
					steps_q <= '0;
					status_q <= cht_pkg::ST_MISS;
					rec_q <= '0;
				end
			end
			cht_pkg::S_HASH: begin
				rem_q <= r2;
				key_q <= {key_q[13:0], key_q[15:14]};
				dcnt_q <= dcnt_q + 1'b1;
				if (dcnt_q == 4'd7) bkt_q <= r2[BW-1:0];
			end
			cht_pkg::S_HEAD: begin
				cur_q <= head_now;
				tail_q <= tail_now;
				if (func_q == cht_pkg::FN_INSERT) begin
					newn_q <= fresh_q[NW-1:0];
					if (!free_valid_q && fresh_q >= (NW+1)'(cht_pkg::POOL))
						status_q <= cht_pkg::ST_FULL;
					else status_q <= cht_pkg::ST_OK;
				end
			end
			cht_pkg::S_NODE_RD: ;
			cht_pkg::S_NODE_CHK: begin
				cur_node_q <= nd_rdata;
				if (key_hit) begin
					status_q <= cht_pkg::ST_OK;
					if (func_q == cht_pkg::FN_SEARCH) rec_q <= nd_rdata.payload;
				end else begin
					prev_q <= cur_q;
					prev_node_q <= nd_rdata;
					has_prev_q <= 1'b1;
					cur_q <= nd_rdata.link;
					steps_q <= steps_q + 1'b1;
				end
			end
			cht_pkg::S_FREE_CHK: begin
				newn_q <= free_head_q;
			end
			cht_pkg::S_WRITE: wphase_q <= wphase_q + 1'b1;
			default: ;
		endcase
		if (state_q == cht_pkg::S_FREE_CHK) free_head_q <= nd_rdata.link;
		if (state_q == cht_pkg::S_WRITE && func_q == cht_pkg::FN_DELETE && wphase_q != 2'd0)
			free_head_q <= cur_q;
	end

	// the tail address goes out in S_HEAD, its word is caught in the following cycle
	always_ff @(posedge clk) begin
		tail_rd_q <= (state_q == cht_pkg::S_HEAD);
		if (tail_rd_q) tail_node_q <= nd_rdata;
	end
endmodule
`default_nettype wire

>>> rtl/cht_checker.sv
// port level checks for the chained hash table
// depends on chained_hash_table port names and cht_pkg
`default_nettype none
module cht_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_ready,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input wire logic [1:0] status,
	input wire logic [31:0] record_out
);
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> status <= cht_pkg::ST_FULL) else $error("bad status");
	a_rec: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != cht_pkg::ST_OK |-> record_out == 32'd0)
		else $error("stray payload");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !req_ready) else $error("ready while result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(record_out)) else $error("drop");
endmodule

bind chained_hash_table cht_checker u_chk (
	.clk(clk), .arst_n(arst_n), .req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .status(rsp.status),
	.record_out(rsp.record_out)
);
`default_nettype wire

>>> tb/cht_tb_pkg.sv
// operation item used by the chained hash table testbench
// depends on cht_pkg
package cht_tb_pkg;
	import cht_pkg::*;

	typedef struct packed {
		logic [1:0] func;
		logic [15:0] key;
		logic [31:0] record_data;
	} op_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [31:0] record_out;
	} op_result_t;
endpackage

>>> tb/chained_hash_table_tb.sv
// testbench for chained_hash_table: random and directed table operations, checked against
// a behavioral table model kept in the testbench; depends on cht_pkg, cht_if and cht_tb_pkg
module chained_hash_table_tb;
	import cht_pkg::*;
	import cht_tb_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	cht_req_if req ();
	cht_rsp_if rsp ();
	cht_cfg_if cfg ();

	chained_hash_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source),
		.cfg(cfg.sink)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// table model
	logic [7:0] m_bucket_count;
	logic [NW-1:0] m_head [BUCKETS];
	logic m_head_v [BUCKETS];
	logic [NW-1:0] m_tail [BUCKETS];
	logic [15:0] m_key [POOL];
	logic [31:0] m_payload [POOL];
	logic [NW-1:0] m_link [POOL];
	logic m_link_v [POOL];
	logic [NW-1:0] m_free;
	logic m_free_v;
	int m_fresh;
	// keys currently stored, used to aim searches and deletes at hits
	logic [15:0] live_keys [$];

	op_item_t pending_ops [$];
	op_result_t expected_results [$];
	int failures = 0;
	bit hold_go = 1'b0;
	bit rx_hold = 1'b0;

	function automatic int bucket_of(logic [15:0] k);
		int m;
		m = (m_bucket_count == 0) ? 256 : int'(m_bucket_count);
		if (m > BUCKETS)
			m = BUCKETS;
		return int'(k) % m;
	endfunction

	function automatic op_result_t table_apply(op_item_t it);
		op_result_t r;
		logic [NW-1:0] n, prev;
		int b, steps;
		bit v, has_prev;
		r.status = ST_MISS;
		r.record_out = '0;
		b = bucket_of(it.key);
		case (func_t'(it.func))
			FN_INSERT: begin
				if (m_free_v) begin
					n = m_free;
					m_free_v = m_link_v[n];
					m_free = m_link[n];
				end else if (m_fresh < POOL) begin
					n = NW'(m_fresh);
					m_fresh++;
				end else begin
					r.status = ST_FULL;
					return r;
				end
				m_key[n] = it.key;
				m_payload[n] = it.record_data;
				m_link[n] = '0;
				m_link_v[n] = 1'b0;
				if (m_head_v[b]) begin
					m_link[m_tail[b]] = n;
					m_link_v[m_tail[b]] = 1'b1;
				end else begin
					m_head[b] = n;
					m_head_v[b] = 1'b1;
				end
				m_tail[b] = n;
				live_keys.push_back(it.key);
				r.status = ST_OK;
			end
			FN_SEARCH, FN_DELETE: begin
				v = m_head_v[b];
				n = m_head[b];
				has_prev = 1'b0;
				prev = '0;
				for (steps = 0; v && steps < POOL; steps++) begin
					if (m_key[n] == it.key) begin
						r.status = ST_OK;
						if (it.func == FN_SEARCH) begin
							r.record_out = m_payload[n];
						end else begin
							if (has_prev) begin
								m_link[prev] = m_link[n];
								m_link_v[prev] = m_link_v[n];
								if (!m_link_v[n])
									m_tail[b] = prev;
							end else begin
								m_head[b] = m_link[n];
								m_head_v[b] = m_link_v[n];
							end
							m_link[n] = m_free;
							m_link_v[n] = m_free_v;
							m_free = n;
							m_free_v = 1'b1;
							foreach (live_keys[i])
								if (live_keys[i] == it.key) begin
									live_keys.delete(i);
									break;
								end
						end
						return r;
					end
					has_prev = 1'b1;
					prev = n;
					v = m_link_v[n];
					n = m_link[n];
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// driver
	int send_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.func <= '0;
			req.key <= '0;
			req.record_data <= '0;
			send_gap <= 0;
		end else begin
			if (req.valid && req.ready) begin
				expected_results.push_back(table_apply({req.func, req.key, req.record_data}));
				send_gap = $urandom_range(0, 5);
				if ($urandom_range(0, 3) == 0)
					send_gap = 0;
			end
			if (!req.valid || req.ready) begin
				if (send_gap > 0 || pending_ops.size() == 0) begin
					req.valid <= 1'b0;
					if (send_gap > 0)
						send_gap <= send_gap - 1;
				end else begin
					op_item_t it;
					it = pending_ops.pop_front();
					req.valid <= 1'b1;
					req.func <= it.func;
					req.key <= it.key;
					req.record_data <= it.record_data;
				end
			end
		end
	end

	// long receiver stall, counted in its own process
	initial begin
		wait (hold_go);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (300) @(posedge clk);
		rx_hold <= 1'b0;
	end

	// monitor
	int recv_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			recv_gap <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result status=%0d record_out=%h", rsp.status,
						rsp.record_out);
					failures++;
				end else begin
					op_result_t e;
					e = expected_results.pop_front();
					if (rsp.status !== e.status) begin
						$error("status expected %0d actual %0d", e.status, rsp.status);
						failures++;
					end
					if (rsp.record_out !== e.record_out) begin
						$error("record_out expected %h actual %h", e.record_out,
							rsp.record_out);
						failures++;
					end
				end
				recv_gap = $urandom_range(0, 5);
				if ($urandom_range(0, 3) == 0)
					recv_gap = 0;
			end
			if (rx_hold) begin
				rsp.ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	task automatic add_op(func_t f, logic [15:0] k, logic [31:0] d);
		pending_ops.push_back({f, k, d});
	endtask

	task automatic drain();
		while (pending_ops.size() != 0 || req.valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_bucket_count(logic [7:0] v);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.data <= v;
		do @(posedge clk); while (!cfg.ready);
		m_bucket_count = v;
		cfg.valid <= 1'b0;
	endtask

	// random phase: mostly inserts and hits on stored keys, with a pool that fills
	task automatic random_ops(int n, int key_span);
		for (int i = 0; i < n; i++) begin
			int sel;
			logic [15:0] k;
			sel = $urandom_range(0, 99);
			k = 16'($urandom_range(0, key_span));
			if (live_keys.size() != 0 && sel >= 40 && sel < 90)
				k = live_keys[$urandom_range(0, live_keys.size() - 1)];
			if (sel < 40)
				add_op(FN_INSERT, k, $urandom());
			else if (sel < 65)
				add_op(FN_SEARCH, k, $urandom());
			else if (sel < 97)
				add_op(FN_DELETE, k, $urandom());
			else
				add_op(FN_NONE, k, $urandom());
		end
	endtask

	initial begin
		m_bucket_count = BUCKET_COUNT_RST;
		foreach (m_head_v[i])
			m_head_v[i] = 1'b0;
		foreach (m_link_v[i])
			m_link_v[i] = 1'b0;
		m_free = '0;
		m_free_v = 1'b0;
		m_fresh = 0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, chains and collisions, unused code, misses
		add_op(FN_SEARCH, 16'h0000, 32'h0);
		add_op(FN_DELETE, 16'hffff, 32'h0);
		add_op(FN_INSERT, 16'h0000, 32'h0000_0000);
		add_op(FN_INSERT, 16'hffff, 32'hffff_ffff);
		add_op(FN_INSERT, 16'd100, 32'h1234_5678);
		add_op(FN_INSERT, 16'd200, 32'hdead_beef);
		add_op(FN_INSERT, 16'd100, 32'h5555_aaaa);
		add_op(FN_SEARCH, 16'd100, 32'h0);
		add_op(FN_SEARCH, 16'd200, 32'h0);
		add_op(FN_SEARCH, 16'hffff, 32'h0);
		add_op(FN_NONE, 16'd200, 32'hffff_ffff);
		add_op(FN_DELETE, 16'd200, 32'h0);
		add_op(FN_SEARCH, 16'd200, 32'h0);
		add_op(FN_DELETE, 16'd100, 32'h0);
		add_op(FN_SEARCH, 16'd100, 32'h0);
		add_op(FN_DELETE, 16'd0, 32'h0);
		add_op(FN_INSERT, 16'd300, 32'haaaa_5555);
		add_op(FN_SEARCH, 16'd300, 32'h0);
		add_op(FN_DELETE, 16'd12345, 32'h0);
		drain();

		// long receiver hold so the block backs up
		hold_go = 1'b1;
		random_ops(100, 65535);
		drain();

		write_bucket_count(8'd1);
		random_ops(200, 65535);
		drain();

		// small keys so the pool fills up and full inserts show up
		write_bucket_count(8'd0);
		for (int i = 0; i < 270; i++)
			add_op(FN_INSERT, 16'($urandom_range(0, 511)), $urandom());
		random_ops(250, 511);
		drain();

		write_bucket_count(8'd255);
		random_ops(350, 65535);
		drain();

		write_bucket_count(8'd7);
		random_ops(300, 1023);
		drain();

		write_bucket_count(8'd128);
		random_ops(250, 65535);
		drain();

		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#60000000;
		$display("Test completed with failures");
		$finish;
	end
endmodule

>>> chained_hash_table.f
rtl/cht_pkg.sv
rtl/cht_if.sv
rtl/cht_ram.sv
rtl/chained_hash_table.sv
rtl/cht_checker.sv
tb/cht_tb_pkg.sv
tb/chained_hash_table_tb.sv
